// ----- rtl/pcxrle_pkg.sv -----
package pcxrle_pkg;

   // longest run that one count byte can carry
   localparam logic [5:0] RUN_CAP    = 6'd63;
   // top two bits set marks a count byte
   localparam logic [7:0] COUNT_MARK = 8'hC0;
   // most bytes one pixel can cause: two runs and a pad
   localparam int unsigned MAX_BEATS = 5;
   localparam int unsigned BEAT_CNT_W = $clog2(MAX_BEATS + 1);
   localparam int unsigned BEAT_IDX_W = $clog2(MAX_BEATS);

   // register indexes on the csr port
   localparam logic [1:0] CSR_LINE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_LINE_COUNT  = 2'd1;
   localparam logic [1:0] CSR_PLANE_COUNT = 2'd2;

   // encoded bytes caused by one pixel
   typedef struct packed {
      logic [MAX_BEATS-1:0][7:0] bytes;
      logic [BEAT_CNT_W-1:0]     count;
      logic                      done;
   } bundle_type;

endpackage

// ----- rtl/pcx_rle_encoder.sv -----
// channel  ports                                  direction
// req      req_valid req_ready req_pixel_byte      in
// rsp      rsp_valid rsp_ready rsp_out_byte
//          rsp_last rsp_image_done                 out
// csr      csr_write_en csr_index csr_wdata        in
//
// a pixel is encoded in the cycle it is taken; its bytes leave the bundle
// register one per cycle while rsp_ready is high, and wait while it is low
// (pixels that cause no byte do not load the bundle register)
// the next pixel is taken in the cycle the last byte of the bundle leaves
// reset is synchronous and active high; it restores register defaults
// and empties the bundle register
module pcx_rle_encoder
   import pcxrle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pixel_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic        rsp_image_done,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   bundle_type bundle;
   logic       accept, load, busy_after;

   // take a pixel once the bundle register frees up
   assign req_ready = !busy_after;
   assign accept    = req_valid && req_ready;
   assign load      = accept && (bundle.count != '0);

   pcxrle_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .pixel_byte   (req_pixel_byte),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .bundle       (bundle)
   );

   pcxrle_ser u_ser (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .bundle     (bundle),
      .busy_after (busy_after),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_byte   (rsp_out_byte),
      .out_last   (rsp_last),
      .out_done   (rsp_image_done)
   );

endmodule

// ----- rtl/pcxrle_core.sv -----
module pcxrle_core
   import pcxrle_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        pixel_byte,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   output bundle_type        bundle
);

   logic [15:0] line_width_ff, line_count_ff;
   logic [2:0]  plane_count_ff;
   logic [7:0]  held_ff, held_in;
   logic [5:0]  run_ff, run_in;
   logic [15:0] column_ff, column_in;
   logic [1:0]  plane_ff, plane_in;
   logic [15:0] line_ff, line_in;

   logic [15:0] w_eff, h_eff;
   logic [2:0]  np_eff;
   logic        emit_a, line_end, plane_end, image_end;
   logic [7:0]  held_mid;
   logic [5:0]  run_mid;
   logic [BEAT_CNT_W-1:0] n;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= 16'd1;
         line_count_ff  <= 16'd1;
         plane_count_ff <= 3'd1;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LINE_WIDTH:  line_width_ff  <= csr_wdata;
            CSR_LINE_COUNT:  line_count_ff  <= csr_wdata;
            CSR_PLANE_COUNT: plane_count_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // run gathering, line flush and byte list for one pixel
   always_comb begin
      w_eff  = (line_width_ff == 16'd0) ? 16'd1 : line_width_ff;
      h_eff  = (line_count_ff == 16'd0) ? 16'd1 : line_count_ff;
      np_eff = (plane_count_ff == 3'd0) ? 3'd1 :
               (plane_count_ff > 3'd4)  ? 3'd4 : plane_count_ff;

      emit_a = (run_ff != 6'd0) && ((pixel_byte != held_ff) || (run_ff >= RUN_CAP));
      if ((run_ff == 6'd0) || emit_a) begin
         held_mid = pixel_byte;
         run_mid  = 6'd1;
      end else begin
         held_mid = held_ff;
         run_mid  = run_ff + 6'd1;
      end

      line_end  = ({1'b0, column_ff} + 17'd1) >= {1'b0, w_eff};
      plane_end = ({1'b0, plane_ff} + 3'd1) >= np_eff;
      image_end = ({1'b0, line_ff} + 17'd1) >= {1'b0, h_eff};

      n = '0;
      bundle.bytes = '0;
      // run closed by a new byte or the cap
      if (emit_a) begin
         if ((run_ff > 6'd1) || (held_ff >= COUNT_MARK)) begin
            bundle.bytes[n[BEAT_IDX_W-1:0]] = COUNT_MARK | {2'b00, run_ff};
            n = n + 1'b1;
         end
         bundle.bytes[n[BEAT_IDX_W-1:0]] = held_ff;
         n = n + 1'b1;
      end
      // flush at plane line end, pad on odd width
      if (line_end) begin
         if ((run_mid > 6'd1) || (held_mid >= COUNT_MARK)) begin
            bundle.bytes[n[BEAT_IDX_W-1:0]] = COUNT_MARK | {2'b00, run_mid};
            n = n + 1'b1;
         end
         bundle.bytes[n[BEAT_IDX_W-1:0]] = held_mid;
         n = n + 1'b1;
         if (w_eff[0]) begin
            bundle.bytes[n[BEAT_IDX_W-1:0]] = 8'h00;
            n = n + 1'b1;
         end
      end
      bundle.count = n;
      bundle.done  = line_end && plane_end && image_end;

      // position update
      held_in   = held_mid;
      run_in    = line_end ? 6'd0 : run_mid;
      column_in = line_end ? 16'd0 : column_ff + 16'd1;
      plane_in  = plane_ff;
      line_in   = line_ff;
      if (line_end) begin
         if (plane_end) begin
            plane_in = 2'd0;
            line_in  = image_end ? 16'd0 : line_ff + 16'd1;
         end else begin
            plane_in = plane_ff + 2'd1;
         end
      end
   end

   // run and position state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         run_ff    <= '0;
         column_ff <= '0;
         plane_ff  <= '0;
         line_ff   <= '0;
      end else if (accept) begin
         held_ff   <= held_in;
         run_ff    <= run_in;
         column_ff <= column_in;
         plane_ff  <= plane_in;
         line_ff   <= line_in;
      end
   end

endmodule

// ----- rtl/pcxrle_ser.sv -----
module pcxrle_ser
   import pcxrle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  bundle_type  bundle,
   output logic        busy_after,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [7:0]  out_byte,
   output logic        out_last,
   output logic        out_done
);

   logic                  valid_ff, valid_in;
   bundle_type            bundle_ff;
   logic [BEAT_IDX_W-1:0] idx_ff, idx_in;
   logic                  beat;

   // current beat from the held bundle
   always_comb begin
      out_valid  = valid_ff;
      out_byte   = bundle_ff.bytes[idx_ff];
      out_last   = ({1'b0, idx_ff} + 1'b1) == bundle_ff.count;
      out_done   = out_last && bundle_ff.done;
      beat       = valid_ff && out_ready;
      busy_after = valid_ff && !(beat && out_last);
   end

   // next bundle slot and beat index
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (beat) begin
         if (out_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // bundle payload
   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= bundle;
      end
   end

endmodule

// ----- rtl/pcxrle_checker.sv -----
module pcxrle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last,
   input logic       rsp_image_done
);

   // stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled rsp beat changed");

   // image end only on a bundle's last byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_image_done && rsp_valid |-> rsp_last)
      else $error("image_done without last");

   // a pixel is taken only when the pending bundle is empty or leaving
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_valid |-> rsp_ready && rsp_last)
      else $error("pixel taken over a pending bundle");

   // bundle keeps going until its last byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("bundle ended early");

   // nothing pending right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind pcx_rle_encoder pcxrle_checker u_pcxrle_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_last       (rsp_last),
   .rsp_image_done (rsp_image_done)
);
